// ===== rtl/rlmb_pkg.sv =====
// Shared types, frame constants and the ray direction tables for the light map block.
// Depends on nothing; rlmb_engine and the top level import it.
package rlmb_pkg;

    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;
    localparam int RAY_LENGTH   = 80;
    localparam int ANGLE_STEPS  = 360;

    localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(PIXELS);
    localparam int ANG_W  = $clog2(ANGLE_STEPS);
    localparam int STEP_W = $clog2(RAY_LENGTH + 1);
    localparam int DIR_W  = 16;
    localparam int FRAC_W = 14;
    localparam int ACC_W  = 26;
    localparam int CRD_W  = ACC_W - FRAC_W;
    localparam int LEVEL_W = 8;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_LIGHT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [8:0] pos_x;
        logic [7:0] pos_y;
        logic       mask_bit;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_level;
        logic       pixel_masked;
    } t_out_item;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    typedef logic signed [DIR_W-1:0] t_dir_tab [ANGLE_STEPS];

    function automatic logic [63:0] f_term_div(logic [63:0] t, int unsigned i, bit want_sin);
        logic [63:0] q;
        case (i)
            1: q = want_sin ? t / 64'd6   : t / 64'd2;
            2: q = want_sin ? t / 64'd20  : t / 64'd12;
            3: q = want_sin ? t / 64'd42  : t / 64'd30;
            4: q = want_sin ? t / 64'd72  : t / 64'd56;
            5: q = want_sin ? t / 64'd110 : t / 64'd90;
            6: q = want_sin ? t / 64'd156 : t / 64'd132;
            7: q = want_sin ? t / 64'd210 : t / 64'd182;
            default: q = want_sin ? t / 64'd272 : t / 64'd240;
        endcase
        return q;
    endfunction

    function automatic logic signed [DIR_W-1:0] f_dir(int unsigned k, bit want_sin);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] u;
        longint      sum;
        bit          neg_c;
        bit          neg_s;
        bit          neg;
        logic signed [DIR_W-1:0] q;
        x = (64'(k) * TWO_PI_Q30) / ANGLE_STEPS;
        neg_c = 1'b0;
        neg_s = 1'b0;
        if (x > PI_Q30) begin
            x = x - PI_Q30;
            neg_c = ~neg_c;
            neg_s = ~neg_s;
        end
        if (x > HALF_PI_Q30) begin
            x = PI_Q30 - x;
            neg_c = ~neg_c;
        end
        x2 = (x * x) >> 30;
        term = want_sin ? x : Q30_ONE;
        sum = longint'(term);
        for (int i = 1; i < 9; i++) begin
            term = f_term_div((term * x2) >> 30, i, want_sin);
            if (i % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(Q30_ONE)) begin
            sum = longint'(Q30_ONE);
        end
        u = (64'(sum) + 64'd32768) >> 16;
        q = DIR_W'(u);
        neg = want_sin ? neg_s : neg_c;
        return neg ? -q : q;
    endfunction

    function automatic t_dir_tab f_dir_tab(bit want_sin);
        t_dir_tab tab;
        for (int k = 0; k < ANGLE_STEPS; k++) begin
            tab[k] = f_dir(k, want_sin);
        end
        return tab;
    endfunction

    localparam t_dir_tab COS_TAB = f_dir_tab(1'b0);
    localparam t_dir_tab SIN_TAB = f_dir_tab(1'b1);

endpackage

// ===== rtl/rlmb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module rlmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== rtl/rlmb_engine.sv =====
// Sequencer over the obstacle mask and light map memories: clear, ray walk, blur, access.
// Depends on rlmb_pkg and rlmb_ram.
module rlmb_engine
    import rlmb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_ready,
    input  t_in_item  i_req,
    output logic      o_rsp_valid,
    input  logic      i_rsp_ready,
    output t_out_item o_rsp
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LCLR, S_RAY_INIT, S_RAY_CALC, S_RAY_READ, S_RAY_UPD,
        S_BLR_ADDR, S_BLR_LAST, S_BLR_AVG1, S_BLR_WR, S_RD_WAIT, S_DONE
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_PIX  = ADDR_W'(PIXELS - 1);
    localparam logic [ADDR_W-1:0] BLR_FIRST = ADDR_W'(FRAME_WIDTH);
    localparam logic [ADDR_W-1:0] BLR_LAST  = ADDR_W'(FRAME_WIDTH * (FRAME_HEIGHT - 1) - 1);
    localparam logic [ADDR_W-1:0] ROW       = ADDR_W'(FRAME_WIDTH);

    t_state                     r_state;
    logic [ADDR_W-1:0]          r_cnt;
    logic [ANG_W-1:0]           r_ang;
    logic [STEP_W-1:0]          r_step;
    logic signed [ACC_W-1:0]    r_acc_x;
    logic signed [ACC_W-1:0]    r_acc_y;
    logic signed [DIR_W-1:0]    r_cos;
    logic signed [DIR_W-1:0]    r_sin;
    logic [8:0]                 r_px;
    logic [7:0]                 r_py;
    logic [ADDR_W-1:0]          r_idx;
    logic [2:0]                 r_phase;
    logic [10:0]                r_sum;
    logic [LEVEL_W-1:0]         r_ctr;
    logic                       r_msk;
    t_out_item                  r_rsp;

    logic                       mask_we;
    logic [ADDR_W-1:0]          mask_waddr;
    logic                       mask_wdata;
    logic [ADDR_W-1:0]          mask_raddr;
    logic                       mask_rd;
    logic                       light_we;
    logic [ADDR_W-1:0]          light_waddr;
    logic [LEVEL_W-1:0]         light_wdata;
    logic [ADDR_W-1:0]          light_raddr;
    logic [LEVEL_W-1:0]         light_rd;

    logic                       in_frame;
    logic [ADDR_W-1:0]          req_addr;
    logic signed [CRD_W-1:0]    x_s;
    logic signed [CRD_W-1:0]    y_s;
    logic                       ray_out;
    logic [ADDR_W-1:0]          ray_addr;
    logic [LEVEL_W-1:0]         sat_level;
    logic [LEVEL_W-1:0]         avg_now;
    logic                       accept;

    function automatic logic [LEVEL_W-1:0] f_div5(logic [10:0] s);
        logic [27:0] p;
        p = 28'(s) * 28'd52429;
        return LEVEL_W'(p >> 18);
    endfunction

    assign accept      = (r_state == S_IDLE) && i_req_valid;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);
    assign o_rsp       = r_rsp;

    assign in_frame = (32'(i_req.pos_x) < FRAME_WIDTH) && (32'(i_req.pos_y) < FRAME_HEIGHT);
    assign req_addr = ADDR_W'(i_req.pos_y) * ROW + ADDR_W'(i_req.pos_x);

    assign x_s = r_acc_x[ACC_W-1:FRAC_W]
               + CRD_W'(r_acc_x[ACC_W-1] && (r_acc_x[FRAC_W-1:0] != '0));
    assign y_s = r_acc_y[ACC_W-1:FRAC_W]
               + CRD_W'(r_acc_y[ACC_W-1] && (r_acc_y[FRAC_W-1:0] != '0));
    assign ray_out = (x_s < 0) || (x_s >= CRD_W'(FRAME_WIDTH)) || (y_s <= 0)
                  || (y_s >= CRD_W'(FRAME_HEIGHT - 1))
                  || (r_step == STEP_W'(RAY_LENGTH));
    assign ray_addr = ADDR_W'(y_s) * ROW + ADDR_W'(x_s);

    assign sat_level = (light_rd >= 8'd240) ? 8'd255 : light_rd + 8'd16;
    assign avg_now   = f_div5(r_sum);

    always_comb begin
        mask_we     = 1'b0;
        mask_waddr  = r_cnt;
        mask_wdata  = 1'b0;
        mask_raddr  = r_cnt;
        light_we    = 1'b0;
        light_waddr = r_cnt;
        light_wdata = '0;
        light_raddr = r_cnt;
        case (r_state)
            S_CLEAR: begin
                mask_we  = 1'b1;
                light_we = 1'b1;
            end
            S_LCLR: begin
                light_we = 1'b1;
            end
            S_IDLE: begin
                mask_we    = accept && (i_req.operation == OP_WRITE) && in_frame;
                mask_waddr = req_addr;
                mask_wdata = i_req.mask_bit;
                mask_raddr = req_addr;
                light_raddr = req_addr;
            end
            S_RAY_READ: begin
                mask_raddr  = r_idx;
                light_raddr = r_idx;
            end
            S_RAY_UPD: begin
                light_we    = !mask_rd;
                light_waddr = r_idx;
                light_wdata = sat_level;
            end
            S_BLR_ADDR: begin
                case (r_phase)
                    3'd0:    light_raddr = r_cnt;
                    3'd1:    light_raddr = r_cnt - ROW;
                    3'd2:    light_raddr = r_cnt - 1'b1;
                    3'd3:    light_raddr = r_cnt + 1'b1;
                    default: light_raddr = r_cnt + ROW;
                endcase
            end
            S_BLR_WR: begin
                light_we    = !r_msk;
                light_wdata = avg_now;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_PIX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_rsp <= '0;
                        r_px  <= i_req.pos_x;
                        r_py  <= i_req.pos_y;
                        r_cnt <= '0;
                        r_ang <= '0;
                        if (i_req.operation == OP_LIGHT) begin
                            r_state <= S_LCLR;
                        end else if (i_req.operation == OP_READ && in_frame) begin
                            r_state <= S_RD_WAIT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RD_WAIT: begin
                    r_rsp.pixel_level  <= light_rd;
                    r_rsp.pixel_masked <= mask_rd;
                    r_state <= S_DONE;
                end
                S_LCLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_PIX) begin
                        r_state <= S_RAY_INIT;
                    end
                end
                S_RAY_INIT: begin
                    r_cos   <= COS_TAB[r_ang];
                    r_sin   <= SIN_TAB[r_ang];
                    r_acc_x <= ACC_W'(r_px) <<< FRAC_W;
                    r_acc_y <= ACC_W'(r_py) <<< FRAC_W;
                    r_step  <= '0;
                    r_state <= S_RAY_CALC;
                end
                S_RAY_CALC: begin
                    r_idx <= ray_addr;
                    if (ray_out) begin
                        if (r_ang == ANG_W'(ANGLE_STEPS - 1)) begin
                            r_cnt   <= BLR_FIRST;
                            r_phase <= '0;
                            r_state <= S_BLR_ADDR;
                        end else begin
                            r_ang   <= r_ang + 1'b1;
                            r_state <= S_RAY_INIT;
                        end
                    end else begin
                        r_state <= S_RAY_READ;
                    end
                end
                S_RAY_READ: begin
                    r_state <= S_RAY_UPD;
                end
                S_RAY_UPD: begin
                    if (mask_rd) begin
                        if (r_ang == ANG_W'(ANGLE_STEPS - 1)) begin
                            r_cnt   <= BLR_FIRST;
                            r_phase <= '0;
                            r_state <= S_BLR_ADDR;
                        end else begin
                            r_ang   <= r_ang + 1'b1;
                            r_state <= S_RAY_INIT;
                        end
                    end else begin
                        r_acc_x <= r_acc_x + ACC_W'(r_cos);
                        r_acc_y <= r_acc_y + ACC_W'(r_sin);
                        r_step  <= r_step + 1'b1;
                        r_state <= S_RAY_CALC;
                    end
                end
                S_BLR_ADDR: begin
                    if (r_phase == 3'd1) begin
                        r_ctr <= light_rd;
                        r_msk <= mask_rd;
                        r_sum <= 11'(light_rd);
                    end else if (r_phase != 3'd0) begin
                        r_sum <= r_sum + 11'(light_rd);
                    end
                    r_phase <= r_phase + 1'b1;
                    if (r_phase == 3'd4) begin
                        r_state <= S_BLR_LAST;
                    end
                end
                S_BLR_LAST: begin
                    r_sum   <= r_sum + 11'(light_rd);
                    r_state <= S_BLR_AVG1;
                end
                S_BLR_AVG1: begin
                    r_sum   <= r_sum - 11'(r_ctr) + 11'(avg_now);
                    r_state <= S_BLR_WR;
                end
                S_BLR_WR: begin
                    r_phase <= '0;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == BLR_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_BLR_ADDR;
                    end
                end
                S_DONE: begin
                    if (i_rsp_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    rlmb_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_mask (
        .i_clk   (i_clk),
        .i_we    (mask_we),
        .i_waddr (mask_waddr),
        .i_wdata (mask_wdata),
        .i_raddr (mask_raddr),
        .o_rdata (mask_rd)
    );

    rlmb_ram #(.WIDTH(LEVEL_W), .DEPTH(PIXELS)) u_light (
        .i_clk   (i_clk),
        .i_we    (light_we),
        .i_waddr (light_waddr),
        .i_wdata (light_wdata),
        .i_raddr (light_raddr),
        .o_rdata (light_rd)
    );
endmodule

// ===== rtl/raycast_light_map_with_blur.sv =====
// Mask writes, out-of-frame items and reads are handled one item at a time.
// A light item clears the light map; per ray, a set-up step, then calc, read and update
// per pixel (an obstacle too), a last calc if it leaves the frame or runs out; then blur.
// The ray walk and blur are bound by the single read port of the light map memory.
// After reset both memories are swept to zero; no item is taken then.
// Depends on rlmb_pkg and rlmb_engine.
module raycast_light_map_with_blur
    import rlmb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);
    logic      eng_valid;
    logic      eng_ready;
    t_out_item eng_rsp;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign eng_ready   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_ready) begin
            r_out_valid <= eng_valid;
            if (eng_valid) begin
                r_out_item <= eng_rsp;
            end
        end
    end

    rlmb_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (i_in_item),
        .o_rsp_valid (eng_valid),
        .i_rsp_ready (eng_ready),
        .o_rsp       (eng_rsp)
    );
endmodule
